>>> design/aos_pkg.sv
// ----------------------------------------------------------------------------
// aos_pkg
// Shared types and constants of the angle offset scheduler.
// ----------------------------------------------------------------------------
package aos_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 32;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LOW_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REV_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_CURRENT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_CURRENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_DELAY = 3'd7;

	// direction codes
	localparam logic [1:0] DIR_NEUTRAL = 2'd0;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	// blend weight of 1.0 in Q16.16
	localparam logic [16:0] T_ONE = 17'h10000;

	typedef struct packed {
		logic signed [31:0] low_load_offset;
		logic signed [31:0] high_load_offset;
		logic signed [31:0] reverse_offset;
		logic [30:0]        entry_current;
		logic [30:0]        exit_current;
		logic [30:0]        blend_gain;
		logic [30:0]        slew_rate;
		logic [23:0]        pwm_delay;
	} cfg_t;

endpackage

>>> design/angle_offset_scheduler.sv
// ----------------------------------------------------------------------------
// angle_offset_scheduler
// Load-dependent angle offset with slew limit and electrical angle output.
// ----------------------------------------------------------------------------
// result: a request runs S_MUL_T, S_MUL_B, S_MUL_S, S_SLEW, S_MUL_P,
//   S_MUL_D, S_SUM; S_SUM waits while out_stall holds the previous result
// requests: one at a time; five products go through the one shared
//   multiplier in turn, and the block holds in_stall until back in S_IDLE
// reset: offset zero, high-current flag clear, last direction neutral,
//   all configuration registers zero
module angle_offset_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [30:0]                     rms_current,
	input  logic [1:0]                      direction,
	input  logic [23:0]                     time_step,
	input  logic signed [31:0]              mech_angle,
	input  logic signed [31:0]              elec_speed,
	input  logic [6:0]                      pole_count,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              applied_offset,
	output logic signed [31:0]              elec_angle,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aos_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import aos_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_T,
		S_MUL_B,
		S_MUL_S,
		S_SLEW,
		S_MUL_P,
		S_MUL_D,
		S_SUM
	} state_t;

	cfg_t cfg;

	state_t state_q;
	logic signed [31:0] offset_q;
	logic               high_q;
	logic [1:0]         prev_dir_q;
	logic               reverse_q;
	logic               blend_q;
	logic [30:0]        diff_q;
	logic [23:0]        dt_q;
	logic signed [31:0] mech_q;
	logic signed [31:0] speed_q;
	logic [6:0]         pp_q;
	logic signed [31:0] target_q;
	logic signed [31:0] pole_q;
	logic               out_valid_q;
	logic signed [31:0] applied_q;
	logic signed [31:0] angle_q;

	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic               hr_base;
	logic               hr_next;
	logic [16:0]        t_w;
	logic signed [33:0] target_sum;
	logic [30:0]        step_w;
	logic signed [32:0] delta_w;
	logic signed [32:0] step_pos;
	logic signed [32:0] step_neg;
	logic signed [31:0] offset_next;
	logic signed [31:0] pole_sat;
	logic signed [31:0] dly_w;
	logic signed [32:0] sum_w;
	logic signed [31:0] sum_sat;
	logic               out_free;

	aos_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aos_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign applied_offset = applied_q;
	assign elec_angle = angle_q;
	assign out_free = !out_valid_q || !out_stall;

	// hysteresis on the incoming request, flag cleared on a direction change
	always_comb begin
		hr_base = (direction != prev_dir_q) ? 1'b0 : high_q;
		hr_next = hr_base;
		if (direction != DIR_REVERSE) begin
			if (!hr_base && (rms_current > cfg.entry_current)) begin
				hr_next = 1'b1;
			end else if (hr_base && (rms_current < cfg.exit_current)) begin
				hr_next = 1'b0;
			end
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_T: begin
				mul_a = {2'b00, diff_q};
				mul_b = {1'b0, cfg.blend_gain};
			end
			S_MUL_B: begin
				mul_a = 33'(cfg.high_load_offset) - 33'(cfg.low_load_offset);
				mul_b = {15'd0, t_w};
			end
			S_MUL_S: begin
				mul_a = {2'b00, cfg.slew_rate};
				mul_b = {8'd0, dt_q};
			end
			S_MUL_P: begin
				mul_a = 33'(mech_q) - 33'(offset_q);
				mul_b = {25'd0, pp_q};
			end
			S_MUL_D: begin
				mul_a = 33'(speed_q);
				mul_b = {8'd0, cfg.pwm_delay};
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// blend weight clamped to one
	always_comb begin
		if (!blend_q) begin
			t_w = '0;
		end else if (prod[63:16] > 48'(T_ONE)) begin
			t_w = T_ONE;
		end else begin
			t_w = prod[32:16];
		end
	end

	assign target_sum = 34'(cfg.low_load_offset) + prod[49:16];

	// slew limit
	assign step_w = prod[54:24];
	assign step_pos = {2'b00, step_w};
	assign step_neg = -step_pos;
	assign delta_w = 33'(target_q) - 33'(offset_q);

	always_comb begin
		if (delta_w > step_pos) begin
			offset_next = offset_q + 32'(step_w);
		end else if (delta_w < step_neg) begin
			offset_next = offset_q - 32'(step_w);
		end else begin
			offset_next = target_q;
		end
	end

	// saturation of the pole product
	always_comb begin
		if (!prod[MUL_P_W-1] && (prod[MUL_P_W-2:31] != '0)) begin
			pole_sat = 32'sh7FFF_FFFF;
		end else if (prod[MUL_P_W-1] && (prod[MUL_P_W-2:31] != '1)) begin
			pole_sat = 32'sh8000_0000;
		end else begin
			pole_sat = prod[31:0];
		end
	end

	assign dly_w = prod[55:24];
	assign sum_w = 33'(pole_q) + 33'(dly_w);

	always_comb begin
		if (sum_w[32] != sum_w[31]) begin
			sum_sat = sum_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum_sat = sum_w[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			offset_q <= '0;
			high_q <= 1'b0;
			prev_dir_q <= DIR_NEUTRAL;
			reverse_q <= 1'b0;
			blend_q <= 1'b0;
			diff_q <= '0;
			dt_q <= '0;
			mech_q <= '0;
			speed_q <= '0;
			pp_q <= '0;
			target_q <= '0;
			pole_q <= '0;
			out_valid_q <= 1'b0;
			applied_q <= '0;
			angle_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_SUM)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						high_q <= hr_next;
						prev_dir_q <= direction;
						reverse_q <= (direction == DIR_REVERSE);
						blend_q <= (direction != DIR_REVERSE) && hr_next &&
							(rms_current > cfg.entry_current);
						diff_q <= rms_current - cfg.entry_current;
						dt_q <= time_step;
						mech_q <= mech_angle;
						speed_q <= elec_speed;
						pp_q <= pole_count;
						state_q <= S_MUL_T;
					end
				end
				S_MUL_T: begin
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					state_q <= S_MUL_S;
				end
				S_MUL_S: begin
					target_q <= reverse_q ? cfg.reverse_offset : target_sum[31:0];
					state_q <= S_SLEW;
				end
				S_SLEW: begin
					offset_q <= offset_next;
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					pole_q <= pole_sat;
					state_q <= S_SUM;
				end
				S_SUM: begin
					// hold the delay product until the result slot is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						applied_q <= offset_q;
						angle_q <= sum_sat;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/aos_cfg.sv
// ----------------------------------------------------------------------------
// aos_cfg
// Configuration register file, written by index over the request channel.
// ----------------------------------------------------------------------------
module aos_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aos_pkg::CFG_DATA_W-1:0]    cfg_data,
	output aos_pkg::cfg_t                     cfg
);
	import aos_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_OFFSET: begin
					regs_q.low_load_offset <= cfg_data;
				end
				REG_HIGH_OFFSET: begin
					regs_q.high_load_offset <= cfg_data;
				end
				REG_REV_OFFSET: begin
					regs_q.reverse_offset <= cfg_data;
				end
				REG_ENTRY_CURRENT: begin
					regs_q.entry_current <= cfg_data[30:0];
				end
				REG_EXIT_CURRENT: begin
					regs_q.exit_current <= cfg_data[30:0];
				end
				REG_BLEND_GAIN: begin
					regs_q.blend_gain <= cfg_data[30:0];
				end
				REG_SLEW_RATE: begin
					regs_q.slew_rate <= cfg_data[30:0];
				end
				REG_PWM_DELAY: begin
					regs_q.pwm_delay <= cfg_data[23:0];
				end
				default: begin
					regs_q <= regs_q;
				end
			endcase
		end
	end

endmodule

>>> design/aos_mul.sv
// ----------------------------------------------------------------------------
// aos_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module aos_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [aos_pkg::MUL_A_W-1:0]  a,
	input  logic signed [aos_pkg::MUL_B_W-1:0]  b,
	output logic signed [aos_pkg::MUL_P_W-1:0]  prod
);
	import aos_pkg::*;

	logic signed [MUL_P_W-1:0] prod_q;

	assign prod = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else if (en) begin
			prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the angle offset scheduler against a cycle-free model of its update.
// Registers are loaded while the block is idle, then a directed set of
// requests and several phases of random requests are sent with random gaps
// and output stalls. Every result is compared with the predicted offset and
// electrical angle in arrival order.
// ----------------------------------------------------------------------------
module tb;
	import aos_pkg::*;

	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_UNUSED = 2'd3;

	localparam int N_PHASES = 8;
	localparam int PHASE_SAMPLES = 120;
	// worst quiet stretch is a long gap plus a long stall plus the busy states
	// of one request; the limit covers it many times over
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 32;

	typedef struct packed {
		logic [30:0]        rms_current;
		logic [1:0]         direction;
		logic [23:0]        time_step;
		logic signed [31:0] mech_angle;
		logic signed [31:0] elec_speed;
		logic [6:0]         pole_count;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] applied_offset;
		logic signed [31:0] elec_angle;
	} offset_angle_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [30:0]           rms_current = '0;
	logic [1:0]            direction = '0;
	logic [23:0]           time_step = '0;
	logic signed [31:0]    mech_angle = '0;
	logic signed [31:0]    elec_speed = '0;
	logic [6:0]            pole_count = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [31:0]    applied_offset;
	logic signed [31:0]    elec_angle;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register contents as seen by the predictor
	cfg_t cfg_shadow = '0;
	// predicted block state
	longint     offset_held = 0;
	bit         high_load = 1'b0;
	logic [1:0] last_dir = DIR_NEUTRAL;

	sample_t       sample_backlog[$];
	offset_angle_t offset_angle_due[$];
	sample_t       cur_sample;
	offset_angle_t due_result;

	int  samples_queued = 0;
	int  samples_taken = 0;
	int  results_checked = 0;
	int  mismatches = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  idle_cycles = 0;
	bit  wait_for_drain = 1'b0;
	bit  calm = 1'b0;
	logic [1:0] dir_run = DIR_FORWARD;
	int  dir_run_left = 0;

	angle_offset_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rms_current(rms_current),
		.direction(direction),
		.time_step(time_step),
		.mech_angle(mech_angle),
		.elec_speed(elec_speed),
		.pole_count(pole_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.applied_offset(applied_offset),
		.elec_angle(elec_angle),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint clamp_s32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// one control update: flag, blend target, slew limit, electrical angle
	function automatic offset_angle_t schedule_offset(input sample_t s);
		longint cur, entry, weight, q, target, step, delta, prod, dly;
		offset_angle_t res;
		cur = longint'(s.rms_current);
		entry = longint'(cfg_shadow.entry_current);
		if (s.direction != last_dir) begin
			high_load = 1'b0;
			last_dir = s.direction;
		end
		if (s.direction == DIR_REVERSE) begin
			target = longint'(cfg_shadow.reverse_offset);
		end else begin
			weight = 0;
			if (!high_load && cur > entry) begin
				high_load = 1'b1;
			end else if (high_load && cur < longint'(cfg_shadow.exit_current)) begin
				high_load = 1'b0;
			end
			if (high_load && cur > entry) begin
				q = ((cur - entry) * longint'(cfg_shadow.blend_gain)) >>> 16;
				weight = (q > longint'(T_ONE)) ? longint'(T_ONE) : q;
			end
			target = (weight * longint'(cfg_shadow.high_load_offset)
				+ (longint'(T_ONE) - weight) * longint'(cfg_shadow.low_load_offset)) >>> 16;
		end
		step = (longint'(cfg_shadow.slew_rate) * longint'(s.time_step)) >>> 24;
		delta = target - offset_held;
		if (delta > step) begin
			offset_held = offset_held + step;
		end else if (delta < -step) begin
			offset_held = offset_held - step;
		end else begin
			offset_held = target;
		end
		prod = clamp_s32(longint'(s.pole_count) * (longint'(s.mech_angle) - offset_held));
		dly = (longint'(s.elec_speed) * longint'(cfg_shadow.pwm_delay)) >>> 24;
		res.applied_offset = offset_held[31:0];
		res.elec_angle = 32'(clamp_s32(prod + dly));
		return res;
	endfunction

	// mostly short idles, a few long ones, none in calm phases
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic cfg_t pick_settings(input int ph);
		cfg_t c;
		int unsigned span;
		c = '0;
		case (ph)
			0: begin
				c.low_load_offset = 32'sd6554;
				c.high_load_offset = 32'sd32768;
				c.reverse_offset = -32'sd13107;
				c.entry_current = 31'd655360;
				c.exit_current = 31'd524288;
				c.blend_gain = 31'd3277;
				c.slew_rate = 31'd13107200;
				c.pwm_delay = 24'd839;
			end
			1, 6: begin
				c.low_load_offset = int'($urandom_range(0, 65536)) - 32768;
				c.high_load_offset = c.low_load_offset + int'($urandom_range(0, 65536));
				c.reverse_offset = -int'($urandom_range(0, 65536));
				c.entry_current = 31'($urandom_range(2, 30) << 16);
				c.exit_current = c.entry_current
					- 31'($urandom_range(0, c.entry_current / 2));
				span = $urandom_range(1, 40);
				c.blend_gain = 31'(65536 / span);
				c.slew_rate = 31'($urandom_range(10, 3000) << 16);
				c.pwm_delay = 24'($urandom_range(0, 3000));
				// hysteresis turned upside down
				if (ph == 6) begin
					c.exit_current = c.entry_current + 31'($urandom_range(0, 5 << 16));
				end
			end
			2: begin
				c.low_load_offset = 32'h80000000;
				c.high_load_offset = 32'h7FFFFFFF;
				c.reverse_offset = 32'h7FFFFFFF;
				c.entry_current = '0;
				c.exit_current = '1;
				c.blend_gain = '1;
				c.slew_rate = '1;
				c.pwm_delay = '1;
			end
			3: begin
				c = '0;
			end
			4: begin
				c.low_load_offset = 32'h7FFFFFFF;
				c.high_load_offset = 32'h80000000;
				c.reverse_offset = 32'h80000000;
				c.entry_current = '1;
				c.exit_current = '0;
				c.blend_gain = 31'd1;
				c.slew_rate = 31'd1;
				c.pwm_delay = 24'd1;
			end
			default: begin
				c.low_load_offset = $urandom;
				c.high_load_offset = $urandom;
				c.reverse_offset = $urandom;
				c.entry_current = 31'($urandom);
				c.exit_current = 31'($urandom);
				c.blend_gain = 31'($urandom);
				c.slew_rate = 31'($urandom);
				c.pwm_delay = 24'($urandom);
			end
		endcase
		return c;
	endfunction

	// called only with the block idle; unused upper data bits get noise
	task automatic load_settings(input cfg_t c);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] word;
		logic [7:0]            spare;
		cfg_valid <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			idx = i[CFG_IDX_W-1:0];
			spare = 8'($urandom);
			case (idx)
				REG_LOW_OFFSET: word = c.low_load_offset;
				REG_HIGH_OFFSET: word = c.high_load_offset;
				REG_REV_OFFSET: word = c.reverse_offset;
				REG_ENTRY_CURRENT: word = {spare[0], c.entry_current};
				REG_EXIT_CURRENT: word = {spare[1], c.exit_current};
				REG_BLEND_GAIN: word = {spare[2], c.blend_gain};
				REG_SLEW_RATE: word = {spare[3], c.slew_rate};
				default: word = {spare, c.pwm_delay};
			endcase
			cfg_index <= idx;
			cfg_data <= word;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_shadow = c;
	endtask

	task automatic queue_sample(input logic [30:0] cur, input logic [1:0] dir,
			input logic [23:0] dt, input logic [31:0] mech, input logic [31:0] speed,
			input logic [6:0] pp);
		sample_t s;
		s.rms_current = cur;
		s.direction = dir;
		s.time_step = dt;
		s.mech_angle = mech;
		s.elec_speed = speed;
		s.pole_count = pp;
		sample_backlog.push_back(s);
		samples_queued++;
	endtask

	// direction held in runs so the hysteresis gets exercised
	task automatic queue_random_sample();
		longint cur;
		int pick;
		logic [1:0] dir;
		logic [23:0] dt;
		logic [31:0] mech, speed;
		logic [6:0] pp;
		if (dir_run_left == 0) begin
			pick = $urandom_range(0, 9);
			dir_run = (pick < 5) ? DIR_FORWARD : (pick < 7) ? DIR_NEUTRAL :
				(pick < 9) ? DIR_REVERSE : DIR_UNUSED;
			dir_run_left = $urandom_range(1, 30);
		end
		dir_run_left--;
		dir = dir_run;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			cur = ($urandom_range(0, 1) ? longint'(cfg_shadow.entry_current)
				: longint'(cfg_shadow.exit_current)) + longint'($urandom_range(0, 1310720))
				- 655360;
		end else if (pick < 70) begin
			cur = longint'($urandom_range(0, 64 << 16));
		end else if (pick < 90) begin
			cur = longint'($urandom) & 64'h7FFFFFFF;
		end else begin
			pick = $urandom_range(0, 3);
			cur = (pick == 0) ? 0 : (pick == 1) ? 64'h7FFFFFFF :
				(pick == 2) ? longint'(cfg_shadow.entry_current) + $urandom_range(0, 1)
				: longint'(cfg_shadow.exit_current) - $urandom_range(0, 1);
		end
		if (cur < 0) cur = 0;
		if (cur > 64'h7FFFFFFF) cur = 64'h7FFFFFFF;
		pick = $urandom_range(0, 99);
		dt = (pick < 70) ? 24'($urandom_range(200, 4000)) : (pick < 90) ? 24'($urandom) :
			(pick < 95) ? 24'h000000 : 24'hFFFFFF;
		mech = $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 2097152)) - 1048576)
			: $urandom;
		speed = $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 8388608)) - 4194304)
			: $urandom;
		pick = $urandom_range(0, 99);
		pp = (pick < 80) ? 7'($urandom_range(1, 64)) : (pick < 90) ? 7'd0
			: 7'($urandom_range(65, 127));
		queue_sample(cur[30:0], dir, dt, mech, speed, pp);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				offset_angle_due.push_back(schedule_offset(cur_sample));
				samples_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (wait_for_drain && results_checked != samples_taken) begin
					in_valid <= 1'b0;
				end else if (sample_backlog.size() != 0) begin
					cur_sample = sample_backlog.pop_front();
					rms_current <= cur_sample.rms_current;
					direction <= cur_sample.direction;
					time_step <= cur_sample.time_step;
					mech_angle <= cur_sample.mech_angle;
					elec_speed <= cur_sample.elec_speed;
					pole_count <= cur_sample.pole_count;
					in_valid <= 1'b1;
					gap_left = pick_idle();
					// at times the next request waits until every result is back
					wait_for_drain = ($urandom_range(0, 63) == 0) || (samples_taken == 40);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch in %s at result %0d: expected %h, got %h",
				what, results_checked, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (offset_angle_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result with no request outstanding: offset %h, angle %h",
							applied_offset, elec_angle);
					end
				end else begin
					due_result = offset_angle_due.pop_front();
					results_checked++;
					if (applied_offset !== due_result.applied_offset) begin
						report_mismatch("applied_offset", due_result.applied_offset,
							applied_offset);
					end
					if (elec_angle !== due_result.elec_angle) begin
						report_mismatch("elec_angle", due_result.elec_angle, elec_angle);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = ($urandom_range(0, 2) == 0) ? pick_idle() : 0;
			end
		end
	end

	// ends a hung run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < N_PHASES; ph++) begin
			calm = (ph == 4);
			load_settings(pick_settings(ph));
			if (ph == 0) begin
				queue_sample(31'd0, DIR_NEUTRAL, 24'd0, 32'd0, 32'd0, 7'd0);
				// flag set with the blend clamped at one, all fields but the pole count at their top
				queue_sample(31'h7FFFFFFF, DIR_FORWARD, 24'hFFFFFF, 32'h7FFFFFFF,
					32'h7FFFFFFF, 7'd64);
				// below exit clears the flag
				queue_sample(31'd100, DIR_FORWARD, 24'd839, 32'h80000000, 32'h80000000, 7'd1);
				// exactly at entry does not set
				queue_sample(cfg_shadow.entry_current, DIR_FORWARD, 24'd839, 32'sd205887,
					32'sd3276800, 7'd4);
				// one above entry sets with a zero blend weight
				queue_sample(cfg_shadow.entry_current + 31'd1, DIR_FORWARD, 24'd839,
					-32'sd205887, -32'sd3276800, 7'd4);
				// between exit and entry while flagged: stays set, target is low offset
				queue_sample(31'd589824, DIR_FORWARD, 24'hFFFFFF, 32'h55555555,
					32'hAAAAAAAA, 7'd2);
				queue_sample(31'd1310720, DIR_FORWARD, 24'hFFFFFF, 32'hAAAAAAAA,
					32'h55555555, 7'd3);
				queue_sample(31'd2621440, DIR_FORWARD, 24'h555555, 32'sd100000,
					32'sd2000000, 7'd8);
				// direction change clears, reverse uses its own offset
				queue_sample(31'd1310720, DIR_REVERSE, 24'hAAAAAA, 32'sd100000,
					-32'sd2000000, 7'd8);
				queue_sample(31'd1310720, DIR_UNUSED, 24'hFFFFFF, 32'sd50000, 32'sd0, 7'd5);
				queue_sample(31'd1310720, DIR_UNUSED, 24'hFFFFFF, -32'sd50000, 32'sd0, 7'd5);
				// no time elapsed: offset frozen
				queue_sample(31'd1310720, DIR_NEUTRAL, 24'd0, 32'sd400000, 32'sd700000, 7'd6);
				queue_sample(31'd786432, DIR_NEUTRAL, 24'd839, 32'sd300000, 32'sd0, 7'd127);
				queue_sample(31'd786432, DIR_NEUTRAL, 24'd839, 32'h7FFFFFFF, 32'd0, 7'd65);
				queue_sample(31'd589824, DIR_NEUTRAL, 24'd839, 32'h80000000, 32'h7FFFFFFF,
					7'd0);
				queue_sample(31'd327680, DIR_FORWARD, 24'hFFFFFF, 32'sd1, -32'sd1, 7'd1);
				queue_sample(31'd0, DIR_REVERSE, 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF,
					7'd127);
				queue_sample(31'h7FFFFFFF, DIR_REVERSE, 24'hFFFFFF, 32'h7FFFFFFF,
					32'h80000000, 7'd64);
			end else begin
				for (int n = 0; n < PHASE_SAMPLES; n++) begin
					queue_random_sample();
				end
			end
			while (results_checked != samples_queued) @(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
